// ===== design/dssd_pkg.sv =====
`timescale 1ns / 1ps

package dssd_pkg;

    // Fixed field widths.
    localparam int unsigned VALUE_W        = 14;
    localparam int unsigned TIME_W         = 16;
    localparam int unsigned BITS_PER_DIGIT = 8;
    localparam int unsigned CFG_IDX_W      = 3;

    localparam int unsigned DIGIT_COUNT_DEFAULT = 4;
    localparam int unsigned QUEUE_DEPTH         = 2;

    localparam logic [BITS_PER_DIGIT-1:0] BLANK_SEG = 8'hFF;

    // Timing register reset values, in microseconds.
    localparam logic [TIME_W-1:0] ONE_LOW_RST    = 16'd1;
    localparam logic [TIME_W-1:0] ONE_HIGH_RST   = 16'd30;
    localparam logic [TIME_W-1:0] ZERO_LOW_RST   = 16'd15;
    localparam logic [TIME_W-1:0] ZERO_HIGH_RST  = 16'd60;
    localparam logic [TIME_W-1:0] LATCH_LOW_RST  = 16'd100;
    localparam logic [TIME_W-1:0] LATCH_HIGH_RST = 16'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_LOW    = 3'd0,
        CFG_ONE_HIGH   = 3'd1,
        CFG_ZERO_LOW   = 3'd2,
        CFG_ZERO_HIGH  = 3'd3,
        CFG_LATCH_LOW  = 3'd4,
        CFG_LATCH_HIGH = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PK_ONE   = 2'd0,
        PK_ZERO  = 2'd1,
        PK_LATCH = 2'd2
    } t_pulse_kind;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CONVERT,
        FS_PUSH
    } t_front_state;

    typedef struct packed {
        logic [TIME_W-1:0] one_low;
        logic [TIME_W-1:0] one_high;
        logic [TIME_W-1:0] zero_low;
        logic [TIME_W-1:0] zero_high;
        logic [TIME_W-1:0] latch_low;
        logic [TIME_W-1:0] latch_high;
    } t_timing;

    function automatic int unsigned pow10(input int unsigned p);
        int unsigned r;
        r = 1;
        for (int unsigned i = 0; i < p; i++) begin
            r = r * 10;
        end
        return r;
    endfunction

    // Active-low segment pattern of one decimal digit.
    function automatic logic [BITS_PER_DIGIT-1:0] seg_of(input logic [3:0] digit);
        logic [BITS_PER_DIGIT-1:0] s;
        unique case (digit)
            4'd0:    s = 8'h03;
            4'd1:    s = 8'h9F;
            4'd2:    s = 8'h25;
            4'd3:    s = 8'h0D;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h49;
            4'd6:    s = 8'h41;
            4'd7:    s = 8'h1F;
            4'd8:    s = 8'h01;
            4'd9:    s = 8'h09;
            default: s = BLANK_SEG;
        endcase
        return s;
    endfunction

endpackage

// ===== design/dssd_front.sv =====
`timescale 1ns / 1ps

module dssd_front #(
    parameter int unsigned DIGIT_COUNT = dssd_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_push,
    output logic                                              o_full,
    input  logic                                              i_cmd,
    input  logic [dssd_pkg::VALUE_W-1:0]                      i_value,
    output logic                                              o_q_push,
    input  logic                                              i_q_full,
    output logic [DIGIT_COUNT*dssd_pkg::BITS_PER_DIGIT-1:0]   o_q_data
);
    import dssd_pkg::*;

    localparam int unsigned BCD_W     = DIGIT_COUNT * 4;
    localparam int unsigned STEP_W    = $clog2(VALUE_W);
    localparam int unsigned MAX_VALUE = pow10(DIGIT_COUNT) - 1;

    t_front_state        r_state, n_state;
    logic                r_clear, n_clear;
    logic [VALUE_W-1:0]  r_shift, n_shift;
    logic [BCD_W-1:0]    r_bcd, n_bcd;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [BCD_W-1:0]    adj;
    logic [VALUE_W-1:0]  sat_value;
    logic                accept;
    logic [DIGIT_COUNT:0] lead;

    assign o_full = (r_state == FS_CONVERT) || ((r_state == FS_PUSH) && i_q_full);
    assign accept = i_push && !o_full;

    // Values beyond the display range show as all nines.
    assign sat_value = (32'(i_value) > MAX_VALUE) ? MAX_VALUE[VALUE_W-1:0] : i_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clear <= n_clear;
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_step  <= n_step;
    end

    // Binary to BCD by shift-and-add-three, one input bit per cycle.
    always_comb begin
        n_state  = r_state;
        n_clear  = r_clear;
        n_shift  = r_shift;
        n_bcd    = r_bcd;
        n_step   = r_step;
        o_q_push = 1'b0;
        adj      = r_bcd;
        for (int d = 0; d < int'(DIGIT_COUNT); d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end
        end
        unique case (r_state)
            FS_IDLE: begin
            end
            FS_CONVERT: begin
                n_bcd   = {adj[BCD_W-2:0], r_shift[VALUE_W-1]};
                n_shift = {r_shift[VALUE_W-2:0], 1'b0};
                n_step  = r_step + STEP_W'(1);
                if (r_step == STEP_W'(VALUE_W - 1)) begin
                    n_state = FS_PUSH;
                end
            end
            FS_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
        if (accept) begin
            n_state = FS_CONVERT;
            n_clear = i_cmd;
            n_shift = sat_value;
            n_bcd   = '0;
            n_step  = '0;
        end
    end

    // Clear blanks all digits; else leading zero digits blank, except the units.
    always_comb begin
        lead[DIGIT_COUNT] = 1'b1;
        for (int p = int'(DIGIT_COUNT) - 1; p >= 0; p--) begin
            lead[p] = lead[p+1] && (r_bcd[p*4 +: 4] == 4'd0);
        end
        o_q_data = '0;
        for (int p = 0; p < int'(DIGIT_COUNT); p++) begin
            if (r_clear || ((p != 0) && lead[p])) begin
                o_q_data[(int'(DIGIT_COUNT)-1-p)*BITS_PER_DIGIT +: BITS_PER_DIGIT] = BLANK_SEG;
            end else begin
                o_q_data[(int'(DIGIT_COUNT)-1-p)*BITS_PER_DIGIT +: BITS_PER_DIGIT] =
                    seg_of(r_bcd[p*4 +: 4]);
            end
        end
    end

    a_last_step_to_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_CONVERT && r_step == STEP_W'(VALUE_W - 1) && !i_push)
            |=> (r_state == FS_PUSH))
        else $error("conversion did not finish after the last bit");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_CONVERT) |-> (r_step <= STEP_W'(VALUE_W - 1)))
        else $error("conversion step counter overran");

endmodule

// ===== design/dssd_queue.sv =====
`timescale 1ns / 1ps

module dssd_queue #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    import dssd_pkg::*;

    localparam int unsigned DEPTH = QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds its depth");

endmodule

// ===== design/dssd_back.sv =====
`timescale 1ns / 1ps

module dssd_back #(
    parameter int unsigned DIGIT_COUNT = dssd_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  dssd_pkg::t_timing                                i_timing,
    input  logic                                             i_q_empty,
    output logic                                             o_q_pop,
    input  logic [DIGIT_COUNT*dssd_pkg::BITS_PER_DIGIT-1:0]  i_q_data,
    output logic                                             o_empty,
    input  logic                                             i_pop,
    output logic [1:0]                                       o_pulse_kind,
    output logic [dssd_pkg::TIME_W-1:0]                      o_low_time,
    output logic [dssd_pkg::TIME_W-1:0]                      o_high_time,
    output logic                                             o_last
);
    import dssd_pkg::*;

    localparam int unsigned SEG_W = DIGIT_COUNT * BITS_PER_DIGIT;
    localparam int unsigned CNT_W = $clog2(SEG_W + 1);

    logic              r_active, n_active;
    logic [SEG_W-1:0]  r_seg, n_seg;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_pulse_kind       r_kind, n_kind;
    logic [TIME_W-1:0] r_low, n_low;
    logic [TIME_W-1:0] r_high, n_high;
    logic              r_last, n_last;
    logic              emit, at_latch;

    assign emit     = r_active && (!r_out_valid || i_pop);
    assign at_latch = (r_cnt == CNT_W'(SEG_W));

    // The next word is taken in the same cycle as the latch pulse, so runs follow
    // without a gap.
    always_comb begin
        n_active    = r_active;
        n_seg       = r_seg;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_low       = r_low;
        n_high      = r_high;
        n_last      = r_last;
        o_q_pop     = !i_q_empty && (!r_active || (emit && at_latch));
        if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
            if (at_latch) begin
                n_kind   = PK_LATCH;
                n_low    = i_timing.latch_low;
                n_high   = i_timing.latch_high;
                n_last   = 1'b1;
                n_active = 1'b0;
                n_cnt    = '0;
            end else begin
                if (r_seg[0]) begin
                    n_kind = PK_ONE;
                    n_low  = i_timing.one_low;
                    n_high = i_timing.one_high;
                end else begin
                    n_kind = PK_ZERO;
                    n_low  = i_timing.zero_low;
                    n_high = i_timing.zero_high;
                end
                n_last = 1'b0;
                n_seg  = r_seg >> 1;
                n_cnt  = r_cnt + CNT_W'(1);
            end
        end
        if (o_q_pop) begin
            n_seg    = i_q_data;
            n_cnt    = '0;
            n_active = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg  <= n_seg;
        r_kind <= n_kind;
        r_low  <= n_low;
        r_high <= n_high;
        r_last <= n_last;
    end

    assign o_empty      = !r_out_valid;
    assign o_pulse_kind = r_kind;
    assign o_low_time   = r_low;
    assign o_high_time  = r_high;
    assign o_last       = r_last;

    a_last_is_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_last == (r_kind == PK_LATCH)))
        else $error("last flag and latch pulse disagree");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cnt <= CNT_W'(SEG_W)))
        else $error("pulse counter overran");

    a_idle_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_cnt == '0))
        else $error("pulse counter not cleared while idle");

endmodule

// ===== design/decimal_seven_segment_pulse_driver.sv =====
`timescale 1ns / 1ps

// Takes a command and a number and sends DIGIT_COUNT active-low seven-segment bytes
// (most significant digit first, leading zeros blanked, a clear command blanking
// every digit), each byte LSB first, as one pulse request per bit followed by one
// latch request with last set; low and high times come from the six timing
// registers. Numbers above the display range show as all nines. Each number yields
// DIGIT_COUNT*8+1 requests (33 by default) and the back end emits one request per
// cycle while pop is held high. The front end converts a number to decimal one
// input bit per cycle and hands the segment bytes on through a two-entry queue,
// so conversion of the next number overlaps the pulse run of the current one.
module decimal_seven_segment_pulse_driver #(
    parameter int unsigned DIGIT_COUNT = dssd_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_cmd,
    input  logic [dssd_pkg::VALUE_W-1:0]    i_value,
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      o_pulse_kind,
    output logic [dssd_pkg::TIME_W-1:0]     o_low_time,
    output logic [dssd_pkg::TIME_W-1:0]     o_high_time,
    output logic                            o_last,
    input  logic                            i_cfg_we,
    input  logic [dssd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dssd_pkg::TIME_W-1:0]     i_cfg_data
);
    import dssd_pkg::*;

    localparam int unsigned SEG_W = DIGIT_COUNT * BITS_PER_DIGIT;

    t_timing          r_timing, n_timing;
    logic             q_push, q_full, q_empty, q_pop;
    logic [SEG_W-1:0] front_data, q_data;

    // Writes to an index beyond the register list are dropped.
    always_comb begin
        n_timing = r_timing;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ONE_LOW:    n_timing.one_low    = i_cfg_data;
                CFG_ONE_HIGH:   n_timing.one_high   = i_cfg_data;
                CFG_ZERO_LOW:   n_timing.zero_low   = i_cfg_data;
                CFG_ZERO_HIGH:  n_timing.zero_high  = i_cfg_data;
                CFG_LATCH_LOW:  n_timing.latch_low  = i_cfg_data;
                CFG_LATCH_HIGH: n_timing.latch_high = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.one_low    <= ONE_LOW_RST;
            r_timing.one_high   <= ONE_HIGH_RST;
            r_timing.zero_low   <= ZERO_LOW_RST;
            r_timing.zero_high  <= ZERO_HIGH_RST;
            r_timing.latch_low  <= LATCH_LOW_RST;
            r_timing.latch_high <= LATCH_HIGH_RST;
        end else begin
            r_timing <= n_timing;
        end
    end

    dssd_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_cmd    (i_cmd),
        .i_value  (i_value),
        .o_q_push (q_push),
        .i_q_full (q_full),
        .o_q_data (front_data)
    );

    dssd_queue #(
        .WIDTH (SEG_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .i_data  (front_data),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    dssd_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_timing     (r_timing),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_q_data     (q_data),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_pulse_kind (o_pulse_kind),
        .o_low_time   (o_low_time),
        .o_high_time  (o_high_time),
        .o_last       (o_last)
    );

endmodule
